// File: rtl/core/bcdcal_pkg.sv
// ----------------------------------------------------------------------------
// bcdcal_pkg
// Shared types, register codes and write masks of the bcd calendar clock.
// ----------------------------------------------------------------------------
package bcdcal_pkg;

  typedef logic [3:0] nibble_t;
  typedef logic [1:0] req_kind_t;

  localparam int BANK_DEPTH = 13;
  typedef logic [BANK_DEPTH-1:0][3:0] bank_t;
  typedef logic [BANK_DEPTH-1:0][7:0] ram_t;

  // request kinds
  localparam req_kind_t REQ_READ  = 2'd0;
  localparam req_kind_t REQ_WRITE = 2'd1;
  localparam req_kind_t REQ_TICK  = 2'd2;

  // bank select in mode bits 1:0
  localparam logic [1:0] BANK_TIME   = 2'd0;
  localparam logic [1:0] BANK_CTRL   = 2'd1;
  localparam logic [1:0] BANK_RAM_LO = 2'd2;
  localparam logic [1:0] BANK_RAM_HI = 2'd3;

  // special offsets
  localparam nibble_t OFF_BANK_LAST = 4'd12;
  localparam nibble_t OFF_MODE      = 4'hD;
  localparam nibble_t OFF_UNUSED    = 4'hE;
  localparam nibble_t OFF_CLEAR     = 4'hF;

  localparam int RUN_BIT   = 3;
  localparam int LEAP_IDX  = 11;
  localparam int CTRL_ONE  = 10;
  localparam int CLEAR_TOP = 4;

  // control bank after reset: all zero but entry ten
  localparam bank_t CTRL_RESET = bank_t'(4'd1) << (4 * CTRL_ONE);

  typedef struct packed {
    req_kind_t kind;
    nibble_t   offset;
    nibble_t   data;
  } req_t;

  function automatic nibble_t time_mask(input nibble_t idx);
    nibble_t m;
    case (idx)
      4'd0, 4'd2, 4'd4, 4'd7, 4'd9, 4'd11, 4'd12: m = 4'hF;
      4'd1, 4'd3, 4'd6:                           m = 4'h7;
      4'd5, 4'd8:                                 m = 4'h3;
      4'd10:                                      m = 4'h1;
      default:                                    m = 4'h0;
    endcase
    return m;
  endfunction

  function automatic nibble_t ctrl_mask(input nibble_t idx);
    nibble_t m;
    case (idx)
      4'd2, 4'd4: m = 4'hF;
      4'd3:       m = 4'h7;
      4'd5, 4'd11: m = 4'h3;
      4'd10:      m = 4'h1;
      default:    m = 4'h0;
    endcase
    return m;
  endfunction

endpackage

// File: rtl/core/bcdcal_tick.sv
// ----------------------------------------------------------------------------
// bcdcal_tick
// Next-second logic: bcd carry chain through time and calendar digits.
// ----------------------------------------------------------------------------
module bcdcal_tick (
  input  bcdcal_pkg::bank_t   time_cur,
  input  bcdcal_pkg::nibble_t leap_cur,
  output bcdcal_pkg::bank_t   time_next,
  output bcdcal_pkg::nibble_t leap_next
);
  import bcdcal_pkg::*;

  function automatic nibble_t inc4(input nibble_t v);
    return v + 4'd1;
  endfunction

  function automatic logic [7:0] dec2(input nibble_t tens, input nibble_t units);
    return ({4'b0, tens} << 3) + ({4'b0, tens} << 1) + {4'b0, units};
  endfunction

  function automatic logic [4:0] wday_inc(input nibble_t v);
    logic [4:0] s;
    s = {1'b0, v} + 5'd1;
    if (s >= 5'd14)     s = s - 5'd14;
    else if (s >= 5'd7) s = s - 5'd7;
    return s;
  endfunction

  function automatic nibble_t decade_inc(input nibble_t v);
    logic [4:0] s;
    s = {1'b0, v} + 5'd1;
    if (s >= 5'd10) s = s - 5'd10;
    return s[3:0];
  endfunction

  function automatic logic [4:0] month_days(input logic [7:0] mon, input logic leap_yr);
    logic [4:0] d;
    case (mon)
      8'd2:                      d = leap_yr ? 5'd29 : 5'd28;
      8'd4, 8'd6, 8'd9, 8'd11:   d = 5'd30;
      default:                   d = 5'd31;
    endcase
    return d;
  endfunction

  bank_t      t;
  logic       done;
  nibble_t    nib;
  nibble_t    hi_u;
  nibble_t    hi_t;
  logic [4:0] max_day;
  logic [4:0] wd;

  always_comb begin
    t        = time_cur;
    leap_next = leap_cur;
    done     = 1'b0;
    hi_u     = '0;
    hi_t     = '0;
    max_day  = 5'd31;
    wd       = '0;

    // seconds and minutes
    nib = inc4(time_cur[0]);
    if (nib <= 4'd9) begin
      t[0] = nib;
      done = 1'b1;
    end else begin
      t[0] = '0;
    end
    if (!done) begin
      nib = inc4(time_cur[1]);
      if (nib <= 4'd5) begin
        t[1] = nib;
        done = 1'b1;
      end else begin
        t[1] = '0;
      end
    end
    if (!done) begin
      nib = inc4(time_cur[2]);
      if (nib <= 4'd9) begin
        t[2] = nib;
        done = 1'b1;
      end else begin
        t[2] = '0;
      end
    end
    if (!done) begin
      nib = inc4(time_cur[3]);
      if (nib <= 4'd5) begin
        t[3] = nib;
        done = 1'b1;
      end else begin
        t[3] = '0;
      end
    end

    // hours
    if (!done) begin
      hi_u = inc4(time_cur[4]);
      hi_t = time_cur[5];
      if (hi_u > 4'd9) begin
        hi_u = '0;
        hi_t = inc4(time_cur[5]);
      end
      if (dec2(hi_t, hi_u) < 8'd24) begin
        t[4] = hi_u;
        t[5] = hi_t;
        done = 1'b1;
      end else begin
        t[4] = '0;
        t[5] = '0;
      end
    end

    // weekday and day of month
    if (!done) begin
      wd   = wday_inc(time_cur[6]);
      t[6] = wd[3:0];
      if (dec2(time_cur[10], time_cur[9]) >= 8'd1 && dec2(time_cur[10], time_cur[9]) <= 8'd12)
      begin
        max_day = month_days(dec2(time_cur[10], time_cur[9]), leap_cur == 4'd0);
      end
      hi_u = inc4(time_cur[7]);
      hi_t = time_cur[8];
      if (hi_u > 4'd9) begin
        hi_u = '0;
        hi_t = inc4(time_cur[8]);
      end
      if (dec2(hi_t, hi_u) <= {3'b0, max_day}) begin
        t[7] = hi_u;
        t[8] = hi_t;
        done = 1'b1;
      end else begin
        t[7] = 4'd1;
        t[8] = '0;
      end
    end

    // month
    if (!done) begin
      hi_u = inc4(time_cur[9]);
      hi_t = time_cur[10];
      if (hi_u > 4'd9) begin
        hi_u = '0;
        hi_t = inc4(time_cur[10]);
      end
      if (dec2(hi_t, hi_u) <= 8'd12) begin
        t[9]  = hi_u;
        t[10] = hi_t;
        done  = 1'b1;
      end else begin
        t[9]  = 4'd1;
        t[10] = '0;
      end
    end

    // year and leap counter
    if (!done) begin
      nib = inc4(time_cur[11]);
      if (nib > 4'd9) begin
        t[11] = '0;
        t[12] = decade_inc(time_cur[12]);
      end else begin
        t[11] = nib;
      end
      leap_next = {2'b00, leap_cur[1:0] + 2'd1};
    end

    time_next = t;
  end

endmodule

// File: rtl/core/bcdcal_regs.sv
// ----------------------------------------------------------------------------
// bcdcal_regs
// Register banks, mode register, host read/write decode and tick update.
// ----------------------------------------------------------------------------
module bcdcal_regs (
  input  logic                clk,
  input  logic                rst,
  input  logic                upd,
  input  bcdcal_pkg::req_t    req,
  output bcdcal_pkg::nibble_t rd_data
);
  import bcdcal_pkg::*;

  bank_t   time_digits;
  bank_t   ctrl_bank;
  ram_t    user_ram;
  nibble_t mode_reg;
  bank_t   time_next;
  nibble_t leap_next;

  bcdcal_tick u_tick (
    .time_cur  (time_digits),
    .leap_cur  (ctrl_bank[LEAP_IDX]),
    .time_next (time_next),
    .leap_next (leap_next)
  );

  // read mux
  always_comb begin
    rd_data = '0;
    if (req.kind == REQ_READ) begin
      if (req.offset == OFF_MODE) begin
        rd_data = mode_reg;
      end else if (req.offset <= OFF_BANK_LAST) begin
        unique case (mode_reg[1:0])
          BANK_TIME:   rd_data = time_digits[req.offset];
          BANK_CTRL:   rd_data = ctrl_bank[req.offset];
          BANK_RAM_LO: rd_data = user_ram[req.offset][3:0];
          BANK_RAM_HI: rd_data = user_ram[req.offset][7:4];
          default:     rd_data = '0;
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      time_digits <= '0;
      ctrl_bank   <= CTRL_RESET;
      user_ram    <= '0;
      mode_reg    <= '0;
    end else if (upd) begin
      case (req.kind)
        REQ_WRITE: begin
          if (req.offset == OFF_MODE) begin
            mode_reg <= req.data;
          end else if (req.offset == OFF_CLEAR) begin
            if (req.data[0]) begin
              ctrl_bank[CLEAR_TOP:0] <= '0;
            end
          end else if (req.offset <= OFF_BANK_LAST) begin
            unique case (mode_reg[1:0])
              BANK_TIME:   time_digits[req.offset] <= req.data & time_mask(req.offset);
              BANK_CTRL:   ctrl_bank[req.offset]   <= req.data & ctrl_mask(req.offset);
              BANK_RAM_LO: user_ram[req.offset][3:0] <= req.data;
              BANK_RAM_HI: user_ram[req.offset][7:4] <= req.data;
              default:     ;
            endcase
          end
        end
        REQ_TICK: begin
          if (mode_reg[RUN_BIT]) begin
            time_digits         <= time_next;
            ctrl_bank[LEAP_IDX] <= leap_next;
          end
        end
        default: ;
      endcase
    end
  end

`ifndef SYNTHESIS
  a_idle_holds: assert property (@(posedge clk) disable iff (rst)
    !upd |=> $stable(time_digits) && $stable(ctrl_bank) && $stable(user_ram)
             && $stable(mode_reg))
    else $error("state changed without a beat");

  a_stopped_tick: assert property (@(posedge clk) disable iff (rst)
    upd && req.kind == REQ_TICK && !mode_reg[RUN_BIT] |=> $stable(time_digits)
                                                          && $stable(ctrl_bank))
    else $error("tick advanced a stopped clock");

  a_mode_write: assert property (@(posedge clk) disable iff (rst)
    upd && req.kind == REQ_WRITE && req.offset == OFF_MODE |=> mode_reg == $past(req.data))
    else $error("mode write lost");

  a_clear: assert property (@(posedge clk) disable iff (rst)
    upd && req.kind == REQ_WRITE && req.offset == OFF_CLEAR && req.data[0]
      |=> ctrl_bank[CLEAR_TOP:0] == '0)
    else $error("control clear incomplete");

  a_ctrl_width: assert property (@(posedge clk) disable iff (rst)
    ctrl_bank[CTRL_ONE][3:1] == 3'd0 && ctrl_bank[LEAP_IDX][3:2] == 2'd0)
    else $error("control entry out of range");
`endif

endmodule

// File: rtl/core/bcd_calendar_clock_registers.sv
// ----------------------------------------------------------------------------
// bcd_calendar_clock_registers
// BCD real-time clock and calendar with sixteen nibble registers.
// ----------------------------------------------------------------------------
// Each beat on the slave side is a read, a write, a one-second tick or a
// no-op and gives exactly one result beat. A beat is taken into an input
// register, the register update and the read mux run once the output
// register can advance, and the result lands in the output register; one
// beat per cycle is sustained while m_tready stays high. The bcd carry chain
// through seconds, minutes, hours, day, month and year is the longest path.
// tready falls only while the output register is held by a low m_tready and
// the input register is full. Offsets 0 to 12 reach the bank chosen by mode
// bits 1:0, offset 13 is the mode register, bit 3 of which enables ticks.
module bcd_calendar_clock_registers (
  input  logic       clk,
  input  logic       rst,
  input  logic       s_tvalid,
  output logic       s_tready,
  input  logic [7:0] s_tdata,   // reg_offset[3:0], write_data[7:4]
  input  logic [1:0] s_tuser,   // req_type[1:0]
  output logic       m_tvalid,
  input  logic       m_tready,
  output logic [7:0] m_tdata    // read_data[3:0], zero[7:4]
);
  import bcdcal_pkg::*;

  logic    in_valid;
  req_t    in_req;
  logic    advance;
  logic    upd;
  nibble_t rd_data;
  nibble_t out_data;

  assign advance  = !m_tvalid || m_tready;
  assign s_tready = !in_valid || advance;
  assign upd      = in_valid && advance;

  bcdcal_regs u_regs (
    .clk     (clk),
    .rst     (rst),
    .upd     (upd),
    .req     (in_req),
    .rd_data (rd_data)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
      m_tvalid <= 1'b0;
    end else begin
      if (advance) begin
        m_tvalid <= in_valid;
      end
      if (s_tready) begin
        in_valid <= s_tvalid;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (upd) begin
      out_data <= rd_data;
    end
    if (s_tready && s_tvalid) begin
      in_req.kind   <= s_tuser;
      in_req.offset <= s_tdata[3:0];
      in_req.data   <= s_tdata[7:4];
    end
  end

  assign m_tdata = {4'b0000, out_data};

endmodule

// File: sim/bcd_calendar_clock_registers_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// bcd_calendar_clock_registers_tb
// Self-checking bench for the bcd calendar clock register file.
// ----------------------------------------------------------------------------
// A short directed table covers the reset values, the mode, unused and clear
// offsets, masked writes and a carry into the leap day. Random episodes follow:
// calendar settings close to every rollover followed by ticks and read-back,
// user ram and control bank traffic, and plain noise. Every result beat is
// compared with an in-order prediction; both stream sides stall in random
// bursts except near the end of the run.
// ----------------------------------------------------------------------------
module bcd_calendar_clock_registers_tb;
  import bcdcal_pkg::*;

  localparam int N_RANDOM    = 900;
  localparam int N_CALM      = 150;
  localparam int CYCLE_LIMIT = 400000;
  localparam int DRAIN_WAIT  = 10;
  localparam int MAX_REPORTS = 10;

  localparam req_kind_t REQ_SPARE = 2'd3;

  // write masks and month lengths, entry 0 in the lowest slot
  localparam bit [12:0][3:0] TIME_KEEP = {
    4'hF, 4'hF, 4'h1, 4'hF, 4'h3, 4'hF, 4'h7, 4'h3, 4'hF, 4'h7, 4'hF, 4'h7, 4'hF};
  localparam bit [12:0][3:0] CTRL_KEEP = {
    4'h0, 4'h3, 4'h1, 4'h0, 4'h0, 4'h0, 4'h0, 4'h3, 4'hF, 4'h7, 4'hF, 4'h0, 4'h0};
  localparam bit [11:0][4:0] MONTH_DAYS = {
    5'd31, 5'd30, 5'd31, 5'd30, 5'd31, 5'd31, 5'd30, 5'd31, 5'd30, 5'd31, 5'd28, 5'd31};

  typedef struct {
    req_kind_t kind;
    nibble_t   offset;
    nibble_t   data;
    bit        fixed;
    nibble_t   want;
  } stim_row_t;

  logic       clk = 1'b0;
  logic       rst;
  logic       s_tvalid;
  logic       s_tready;
  logic [7:0] s_tdata;   // reg_offset[3:0], write_data[7:4]
  logic [1:0] s_tuser;   // req_type[1:0]
  logic       m_tvalid;
  logic       m_tready;
  logic [7:0] m_tdata;   // read_data[3:0], zero[7:4]

  bcd_calendar_clock_registers uut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // calendar state as the host sees it
  nibble_t  cal_digit [BANK_DEPTH];
  nibble_t  cal_ctrl  [BANK_DEPTH];
  logic [7:0] cal_ram [BANK_DEPTH];
  nibble_t  cal_mode;

  stim_row_t stim_rows [$];
  nibble_t   read_data_due [$];

  bit      calm;
  bit      row_fixed;
  nibble_t row_want;
  nibble_t beat_want;
  nibble_t beat_got;
  int      cycle_count;
  int      error_count;
  int      checked_count;
  int      sent_count;
  int      tick_count;
  int      n_directed;

  function automatic void cal_clear();
    for (int i = 0; i < BANK_DEPTH; i++) begin
      cal_digit[i] = 4'h0;
      cal_ctrl[i]  = 4'h0;
      cal_ram[i]   = 8'h00;
    end
    cal_ctrl[CTRL_ONE] = 4'h1;
    cal_mode = 4'h0;
  endfunction

  function automatic nibble_t cal_read(nibble_t off);
    if (off == OFF_MODE) return cal_mode;
    if (off >= OFF_UNUSED) return 4'h0;
    case (cal_mode[1:0])
      BANK_TIME:   return cal_digit[off];
      BANK_CTRL:   return cal_ctrl[off];
      BANK_RAM_LO: return cal_ram[off][3:0];
      default:     return cal_ram[off][7:4];
    endcase
  endfunction

  function automatic void cal_write(nibble_t off, nibble_t d);
    if (off == OFF_MODE) begin
      cal_mode = d;
    end else if (off == OFF_CLEAR) begin
      if (d[0]) begin
        for (int i = 0; i <= CLEAR_TOP; i++) cal_ctrl[i] = 4'h0;
      end
    end else if (off != OFF_UNUSED) begin
      case (cal_mode[1:0])
        BANK_TIME:   cal_digit[off] = d & TIME_KEEP[off];
        BANK_CTRL:   cal_ctrl[off] = d & CTRL_KEEP[off];
        BANK_RAM_LO: cal_ram[off][3:0] = d;
        default:     cal_ram[off][7:4] = d;
      endcase
    end
  endfunction

  // one second forward; digits wrap at 16 before any compare
  function automatic void cal_tick();
    int mon;
    int maxd;
    if (!cal_mode[RUN_BIT]) return;
    cal_digit[0] = cal_digit[0] + 4'd1;
    if (cal_digit[0] <= 9) return;
    cal_digit[0] = 4'h0;
    cal_digit[1] = cal_digit[1] + 4'd1;
    if (cal_digit[1] <= 5) return;
    cal_digit[1] = 4'h0;
    cal_digit[2] = cal_digit[2] + 4'd1;
    if (cal_digit[2] <= 9) return;
    cal_digit[2] = 4'h0;
    cal_digit[3] = cal_digit[3] + 4'd1;
    if (cal_digit[3] <= 5) return;
    cal_digit[3] = 4'h0;

    cal_digit[4] = cal_digit[4] + 4'd1;
    if (cal_digit[4] > 9) begin
      cal_digit[4] = 4'h0;
      cal_digit[5] = cal_digit[5] + 4'd1;
    end
    if (int'(cal_digit[5]) * 10 + int'(cal_digit[4]) < 24) return;
    cal_digit[4] = 4'h0;
    cal_digit[5] = 4'h0;

    cal_digit[6] = nibble_t'((int'(cal_digit[6]) + 1) % 7);

    mon  = int'(cal_digit[10]) * 10 + int'(cal_digit[9]);
    maxd = 31;
    if (mon >= 1 && mon <= 12) begin
      maxd = MONTH_DAYS[mon - 1];
      if (mon == 2 && cal_ctrl[LEAP_IDX] == 4'h0) maxd = 29;
    end

    cal_digit[7] = cal_digit[7] + 4'd1;
    if (cal_digit[7] > 9) begin
      cal_digit[7] = 4'h0;
      cal_digit[8] = cal_digit[8] + 4'd1;
    end
    if (int'(cal_digit[8]) * 10 + int'(cal_digit[7]) <= maxd) return;
    cal_digit[7] = 4'h1;
    cal_digit[8] = 4'h0;

    cal_digit[9] = cal_digit[9] + 4'd1;
    if (cal_digit[9] > 9) begin
      cal_digit[9] = 4'h0;
      cal_digit[10] = cal_digit[10] + 4'd1;
    end
    if (int'(cal_digit[10]) * 10 + int'(cal_digit[9]) <= 12) return;
    cal_digit[9] = 4'h1;
    cal_digit[10] = 4'h0;

    cal_digit[11] = cal_digit[11] + 4'd1;
    if (cal_digit[11] > 9) begin
      cal_digit[11] = 4'h0;
      cal_digit[12] = nibble_t'((int'(cal_digit[12]) + 1) % 10);
    end
    cal_ctrl[LEAP_IDX] = (cal_ctrl[LEAP_IDX] + 4'd1) & 4'h3;
  endfunction

  function automatic nibble_t cal_step(req_kind_t kind, nibble_t off, nibble_t d);
    nibble_t rd;
    rd = 4'h0;
    case (kind)
      REQ_READ:  rd = cal_read(off);
      REQ_WRITE: cal_write(off, d);
      REQ_TICK:  cal_tick();
      default:   ;
    endcase
    return rd;
  endfunction

  function automatic void add_row(req_kind_t kind, nibble_t off, nibble_t d,
                                  bit fixed = 1'b0, nibble_t want = 4'h0);
    stim_row_t r;
    r.kind   = kind;
    r.offset = off;
    r.data   = d;
    r.fixed  = fixed;
    r.want   = want;
    stim_rows.push_back(r);
  endfunction

  // mostly the given rollover value, sometimes any nibble
  function automatic nibble_t near(nibble_t v);
    return ($urandom_range(0, 3) == 0) ? nibble_t'($urandom_range(0, 15)) : v;
  endfunction

  function automatic void load_directed();
    //       kind       offset               data               fixed  want
    add_row(REQ_READ,  4'd0,                4'h0,              1'b1,  4'h0);
    add_row(REQ_READ,  OFF_MODE,            4'h0,              1'b1,  4'h0);
    add_row(REQ_READ,  OFF_UNUSED,          4'h0,              1'b1,  4'h0);
    add_row(REQ_READ,  OFF_CLEAR,           4'hF,              1'b1,  4'h0);
    add_row(REQ_SPARE, OFF_CLEAR,           4'hF,              1'b1,  4'h0);
    add_row(REQ_WRITE, OFF_MODE,            {2'b00, BANK_CTRL}, 1'b1, 4'h0);
    add_row(REQ_READ,  nibble_t'(CTRL_ONE), 4'h0,              1'b1,  4'h1);
    add_row(REQ_READ,  nibble_t'(LEAP_IDX), 4'h0,              1'b1,  4'h0);
    add_row(REQ_WRITE, 4'd2,                4'hF,              1'b1,  4'h0);
    add_row(REQ_WRITE, OFF_CLEAR,           4'hF,              1'b1,  4'h0);
    add_row(REQ_WRITE, OFF_UNUSED,          4'hF,              1'b1,  4'h0);
    add_row(REQ_READ,  4'd2,                4'h0,              1'b1,  4'h0);
    add_row(REQ_WRITE, OFF_MODE,            {2'b00, BANK_TIME}, 1'b1, 4'h0);
    add_row(REQ_WRITE, 4'd0,                4'h9,              1'b1,  4'h0);
    add_row(REQ_WRITE, 4'd1,                4'hF,              1'b1,  4'h0);
    add_row(REQ_WRITE, 4'd2,                4'h9,              1'b1,  4'h0);
    add_row(REQ_WRITE, 4'd3,                4'h5,              1'b1,  4'h0);
    add_row(REQ_WRITE, 4'd4,                4'h3,              1'b1,  4'h0);
    add_row(REQ_WRITE, 4'd5,                4'h2,              1'b1,  4'h0);
    add_row(REQ_WRITE, 4'd7,                4'h8,              1'b1,  4'h0);
    add_row(REQ_WRITE, 4'd8,                4'h2,              1'b1,  4'h0);
    add_row(REQ_WRITE, 4'd9,                4'h2,              1'b1,  4'h0);
    add_row(REQ_WRITE, OFF_MODE,            {2'b10, BANK_TIME}, 1'b1, 4'h0);
    add_row(REQ_TICK,  4'd0,                4'h0,              1'b1,  4'h0);
    add_row(REQ_READ,  4'd7,                4'h0);
    add_row(REQ_READ,  4'd1,                4'h0);
  endfunction

  // calendar set just short of a rollover, then ticks and read-back
  function automatic void add_calendar_episode();
    int      mon;
    int      day;
    int      n;
    nibble_t run_mode;
    mon = ($urandom_range(0, 7) == 0) ? $urandom_range(0, 19) : $urandom_range(1, 12);
    if (mon >= 1 && mon <= 12) day = MONTH_DAYS[mon - 1];
    else day = 31;
    if (mon == 2) day = $urandom_range(28, 29);
    if ($urandom_range(0, 3) == 0) day = $urandom_range(0, 39);

    add_row(REQ_WRITE, OFF_MODE, {2'b00, BANK_TIME});
    add_row(REQ_WRITE, 4'd0, near(4'h9));
    add_row(REQ_WRITE, 4'd1, near(4'h5));
    add_row(REQ_WRITE, 4'd2, near(4'h9));
    add_row(REQ_WRITE, 4'd3, near(4'h5));
    add_row(REQ_WRITE, 4'd4, near($urandom_range(0, 1) ? 4'h3 : 4'h9));
    add_row(REQ_WRITE, 4'd5, near($urandom_range(0, 1) ? 4'h2 : 4'h1));
    add_row(REQ_WRITE, 4'd6, near(4'h6));
    add_row(REQ_WRITE, 4'd7, near(nibble_t'(day % 10)));
    add_row(REQ_WRITE, 4'd8, nibble_t'(day / 10));
    add_row(REQ_WRITE, 4'd9, nibble_t'(mon % 10));
    add_row(REQ_WRITE, 4'd10, nibble_t'(mon / 10));
    add_row(REQ_WRITE, 4'd11, near(4'h9));
    add_row(REQ_WRITE, 4'd12, near(4'h9));
    if ($urandom_range(0, 1)) begin
      add_row(REQ_WRITE, OFF_MODE, {2'b00, BANK_CTRL});
      add_row(REQ_WRITE, nibble_t'(LEAP_IDX), nibble_t'($urandom_range(0, 15)));
    end

    run_mode = {($urandom_range(0, 5) != 0), 1'($urandom_range(0, 1)), BANK_TIME};
    add_row(REQ_WRITE, OFF_MODE, run_mode);
    n = $urandom_range(1, 8);
    for (int i = 0; i < n; i++) begin
      add_row(REQ_TICK, nibble_t'($urandom_range(0, 15)), nibble_t'($urandom_range(0, 15)));
      if ($urandom_range(0, 2) == 0) add_row(REQ_READ, nibble_t'($urandom_range(0, 12)), 4'h0);
    end
    for (int off = 0; off < BANK_DEPTH; off++) begin
      if ($urandom_range(0, 1)) add_row(REQ_READ, nibble_t'(off), 4'h0);
    end
    add_row(REQ_WRITE, OFF_MODE, {run_mode[3:2], BANK_CTRL});
    add_row(REQ_READ, nibble_t'(LEAP_IDX), 4'h0);
  endfunction

  function automatic void add_ram_episode();
    int n;
    n = $urandom_range(4, 12);
    for (int i = 0; i < n; i++) begin
      add_row(REQ_WRITE, OFF_MODE,
              {1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)),
               $urandom_range(0, 1) ? BANK_RAM_HI : BANK_RAM_LO});
      add_row($urandom_range(0, 1) ? REQ_WRITE : REQ_READ,
              nibble_t'($urandom_range(0, 12)), nibble_t'($urandom_range(0, 15)));
      add_row(REQ_READ, nibble_t'($urandom_range(0, 12)), 4'h0);
    end
  endfunction

  function automatic void add_ctrl_episode();
    int n;
    n = $urandom_range(3, 10);
    add_row(REQ_WRITE, OFF_MODE, {1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)), BANK_CTRL});
    for (int i = 0; i < n; i++) begin
      add_row(REQ_WRITE, nibble_t'($urandom_range(0, 12)), nibble_t'($urandom_range(0, 15)));
      add_row(REQ_READ, nibble_t'($urandom_range(0, 12)), 4'h0);
    end
    add_row(REQ_WRITE, OFF_CLEAR, nibble_t'($urandom_range(0, 15)));
    for (int off = 0; off <= CLEAR_TOP + 1; off++) add_row(REQ_READ, nibble_t'(off), 4'h0);
  endfunction

  function automatic void add_noise();
    int n;
    n = $urandom_range(5, 15);
    for (int i = 0; i < n; i++) begin
      add_row(req_kind_t'($urandom_range(0, 3)), nibble_t'($urandom_range(0, 15)),
              nibble_t'($urandom_range(0, 15)));
    end
  endfunction

  task automatic report_error(string what, nibble_t want, logic [7:0] got);
    error_count++;
    if (error_count <= MAX_REPORTS)
      $display("[%0t] %s: expected read_data %h, got m_tdata %h", $time, what, want, got);
  endtask

  // result check and prediction, both on pre-edge values
  always @(posedge clk) begin
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d results still due",
               cycle_count, read_data_due.size());
      $display("Test completed with failures");
      $finish;
    end else begin
      cycle_count++;
      if (!rst && m_tvalid && m_tready) begin
        if (read_data_due.size() == 0) begin
          report_error("unexpected beat", 4'h0, m_tdata);
        end else begin
          beat_want = read_data_due.pop_front();
          checked_count++;
          if (m_tdata !== {4'h0, beat_want}) report_error("mismatch", beat_want, m_tdata);
        end
      end
      if (!rst && s_tvalid && s_tready) begin
        if (s_tuser == REQ_TICK && cal_mode[RUN_BIT]) tick_count++;
        beat_got = cal_step(s_tuser, s_tdata[3:0], s_tdata[7:4]);
        read_data_due.push_back(row_fixed ? row_want : beat_got);
      end
    end
  end

  // result side back-pressure
  initial begin
    int stall_odds;
    m_tready = 1'b1;
    stall_odds = 0;
    forever begin
      @(negedge clk);
      if (cycle_count % 64 == 0) stall_odds = $urandom_range(0, 3);
      if (!calm && stall_odds != 0 && $urandom_range(0, 15) < stall_odds) begin
        m_tready = 1'b0;
        repeat ($urandom_range(1, 19) - 1) @(negedge clk);
      end else begin
        m_tready = 1'b1;
      end
    end
  end

  initial begin
    int gap_odds;
    rst       = 1'b1;
    s_tvalid  = 1'b0;
    s_tdata   = 8'h00;
    s_tuser   = REQ_READ;
    row_fixed = 1'b0;
    row_want  = 4'h0;
    calm      = 1'b0;
    gap_odds  = 0;
    cal_clear();

    load_directed();
    n_directed = stim_rows.size();
    while (stim_rows.size() < n_directed + N_RANDOM) begin
      case ($urandom_range(0, 9))
        0, 1, 2, 3, 4: add_calendar_episode();
        5, 6:          add_ram_episode();
        7:             add_ctrl_episode();
        default:       add_noise();
      endcase
    end

    repeat (8) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    for (int i = 0; i < stim_rows.size(); i++) begin
      if (i >= stim_rows.size() - N_CALM) calm = 1'b1;
      if (i % 64 == 0) gap_odds = $urandom_range(0, 3);
      @(negedge clk);
      if (!calm && gap_odds != 0 && $urandom_range(0, 15) < gap_odds) begin
        s_tvalid = 1'b0;
        repeat ($urandom_range(1, 19)) @(negedge clk);
      end
      s_tvalid  = 1'b1;
      s_tuser   = stim_rows[i].kind;
      s_tdata   = {stim_rows[i].data, stim_rows[i].offset};
      row_fixed = stim_rows[i].fixed;
      row_want  = stim_rows[i].want;
      do @(posedge clk); while (!s_tready);
      sent_count++;
    end
    @(negedge clk);
    s_tvalid = 1'b0;

    while (read_data_due.size() != 0) @(posedge clk);
    repeat (DRAIN_WAIT) @(posedge clk);

    $display("%0d beats sent (%0d directed), %0d results checked, %0d running ticks",
             sent_count, n_directed, checked_count, tick_count);
    $display("%0d errors, %0d results left unmatched", error_count, read_data_due.size());
    if (error_count == 0 && read_data_due.size() == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule

// File: files.f
rtl/core/bcdcal_pkg.sv
rtl/core/bcdcal_tick.sv
rtl/core/bcdcal_regs.sv
rtl/core/bcd_calendar_clock_registers.sv
sim/bcd_calendar_clock_registers_tb.sv
